>>> design/els_pkg.sv
// Package for the LOOK elevator scheduler: floor count, types, command codes
// and priority-encoder functions. No dependencies.
`timescale 1ns / 1ps

package els_pkg;

    localparam int NUM_FLOORS = 16;
    localparam int FLOOR_W    = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
    localparam int CALL_W     = 4;
    localparam int CAR_W      = 4;

    typedef logic [NUM_FLOORS-1:0] t_calls;
    typedef logic [FLOOR_W-1:0]    t_floor;

    typedef enum logic {
        CMD_CALL = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef struct packed {
        logic   found;
        logic   reverse;
        t_floor target;
        t_calls up_calls;
        t_calls down_calls;
    } t_pick;

    function automatic t_floor lowest_idx(input t_calls v);
        t_floor f;
        f = '0;
        for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
            if (v[i]) f = FLOOR_W'(i);
        end
        return f;
    endfunction

    function automatic t_floor highest_idx(input t_calls v);
        t_floor f;
        f = '0;
        for (int i = 0; i < NUM_FLOORS; i++) begin
            if (v[i]) f = FLOOR_W'(i);
        end
        return f;
    endfunction

endpackage

>>> design/els_pick.sv
// Target chooser: scans the call bits ahead of the car in LOOK order and
// returns the chosen floor and the updated call sets. Depends on els_pkg.
`timescale 1ns / 1ps

module els_pick (
    input  els_pkg::t_calls i_up_calls,
    input  els_pkg::t_calls i_down_calls,
    input  els_pkg::t_floor i_floor,
    input  logic            i_going_up,
    output els_pkg::t_pick  o_pick
);

    els_pkg::t_calls here;
    els_pkg::t_calls above;
    els_pkg::t_calls below;
    els_pkg::t_calls ahead;
    els_pkg::t_calls same;
    els_pkg::t_calls other;
    els_pkg::t_calls same_ahead;
    els_pkg::t_calls other_ahead;

    assign here  = els_pkg::t_calls'(1) << i_floor;
    assign above = ~((here << 1) - els_pkg::t_calls'(1));
    assign below = here - els_pkg::t_calls'(1);
    assign ahead = i_going_up ? above : below;
    assign same  = i_going_up ? i_up_calls : i_down_calls;
    assign other = i_going_up ? i_down_calls : i_up_calls;
    assign same_ahead  = same & ahead;
    assign other_ahead = other & ahead;

    always_comb begin
        els_pkg::t_calls n_same;
        els_pkg::t_calls n_other;
        n_same          = same;
        n_other         = other;
        o_pick.found    = 1'b0;
        o_pick.reverse  = 1'b0;
        o_pick.target   = i_floor;
        if ((same & here) != '0) begin
            o_pick.found  = 1'b1;
            n_same        = same & ~here;
        end else if (same_ahead != '0) begin
            o_pick.found  = 1'b1;
            o_pick.target = i_going_up ? els_pkg::lowest_idx(same_ahead)
                                       : els_pkg::highest_idx(same_ahead);
            n_same        = same & ~(els_pkg::t_calls'(1) << o_pick.target);
        end else if (other_ahead != '0) begin
            o_pick.found  = 1'b1;
            o_pick.target = i_going_up ? els_pkg::highest_idx(other_ahead)
                                       : els_pkg::lowest_idx(other_ahead);
            n_other       = other & ~(els_pkg::t_calls'(1) << o_pick.target);
        end else begin
            o_pick.reverse = ((i_up_calls | i_down_calls) != '0);
        end
        o_pick.up_calls   = i_going_up ? n_same : n_other;
        o_pick.down_calls = i_going_up ? n_other : n_same;
    end

endmodule

>>> design/elevator_look_scheduler.sv
// LOOK elevator scheduler top level: input register, call/tick logic, result
// register. Depends on els_pkg and els_pick.
//
// Usage:
//   Input channel (i_valid / o_stall) carries i_cmd, i_call_floor, i_call_down.
//   A call (i_cmd = 0) sets the up or down call bit of a floor; o_status = 1
//   marks a duplicate that was ignored. A tick (i_cmd = 1) picks a target if
//   none is pending and moves the car one floor toward it.
//   Output channel (o_valid / i_stall) returns one result per item: car floor,
//   heading, moving and arrived flags, status.
//   An item passes the input register, then the result register, before its
//   result is valid. Throughput: one item per cycle unless i_stall holds it,
//   set by the single pass through the target chooser's priority encoders.
//   When the receiver stalls, the result register holds; the input register
//   keeps one more item, after which o_stall rises until the result is taken.
//   Reset (synchronous, active low): no calls, car at floor 0 heading up, no
//   target, both registers empty.
`timescale 1ns / 1ps

module elevator_look_scheduler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_cmd,
    input  logic [3:0] i_call_floor,
    input  logic       i_call_down,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_car_floor,
    output logic       o_heading_up,
    output logic       o_moving,
    output logic       o_arrived,
    output logic       o_status
);

    logic                           r_in_valid;
    els_pkg::t_cmd                  r_in_cmd;
    logic [els_pkg::CALL_W-1:0]     r_in_floor;
    logic                           r_in_down;

    els_pkg::t_calls                r_up_calls,   n_up_calls;
    els_pkg::t_calls                r_down_calls, n_down_calls;
    els_pkg::t_floor                r_floor,      n_floor;
    logic                           r_going_up,   n_going_up;
    els_pkg::t_floor                r_target,     n_target;
    logic                           r_has_target, n_has_target;
    logic                           n_arrived;
    logic                           n_dup;

    logic                           r_out_valid;
    logic [els_pkg::CAR_W-1:0]      r_out_floor;
    logic                           r_out_up;
    logic                           r_out_moving;
    logic                           r_out_arrived;
    logic                           r_out_status;

    logic                           out_blocked;
    logic                           advance;
    logic                           in_xfer;
    els_pkg::t_pick                 pick;

    assign out_blocked = r_out_valid & i_stall;
    assign advance     = r_in_valid & ~out_blocked;
    assign o_stall     = r_in_valid & out_blocked;
    assign in_xfer     = i_valid & ~o_stall;

    els_pick u_pick (
        .i_up_calls   (r_up_calls),
        .i_down_calls (r_down_calls),
        .i_floor      (r_floor),
        .i_going_up   (r_going_up),
        .o_pick       (pick)
    );

    always_comb begin
        els_pkg::t_calls bit_mask;
        bit_mask     = els_pkg::t_calls'(1) << r_in_floor;
        n_up_calls   = r_up_calls;
        n_down_calls = r_down_calls;
        n_floor      = r_floor;
        n_going_up   = r_going_up;
        n_target     = r_target;
        n_has_target = r_has_target;
        n_arrived    = 1'b0;
        n_dup        = 1'b0;
        case (r_in_cmd)
            els_pkg::CMD_CALL: begin
                if (32'(r_in_floor) < els_pkg::NUM_FLOORS) begin
                    if (r_in_down) begin
                        if ((r_down_calls & bit_mask) != '0) n_dup = 1'b1;
                        else n_down_calls = r_down_calls | bit_mask;
                    end else begin
                        if ((r_up_calls & bit_mask) != '0) n_dup = 1'b1;
                        else n_up_calls = r_up_calls | bit_mask;
                    end
                end
            end
            els_pkg::CMD_TICK: begin
                if (!r_has_target) begin
                    n_up_calls   = pick.up_calls;
                    n_down_calls = pick.down_calls;
                    n_has_target = pick.found;
                    if (pick.found) n_target = pick.target;
                    if (pick.reverse) n_going_up = ~r_going_up;
                end
                if (n_has_target) begin
                    if (r_floor < n_target) begin
                        n_going_up = 1'b1;
                        n_floor    = r_floor + els_pkg::t_floor'(1);
                    end else if (r_floor > n_target) begin
                        n_going_up = 1'b0;
                        n_floor    = r_floor - els_pkg::t_floor'(1);
                    end
                    if (n_floor == n_target) begin
                        n_arrived    = 1'b1;
                        n_has_target = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_up_calls   <= '0;
            r_down_calls <= '0;
            r_floor      <= '0;
            r_going_up   <= 1'b1;
            r_target     <= '0;
            r_has_target <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_up_calls   <= n_up_calls;
                r_down_calls <= n_down_calls;
                r_floor      <= n_floor;
                r_going_up   <= n_going_up;
                r_target     <= n_target;
                r_has_target <= n_has_target;
            end else if (!i_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_cmd   <= els_pkg::t_cmd'(i_cmd);
            r_in_floor <= i_call_floor;
            r_in_down  <= i_call_down;
        end
        if (advance) begin
            r_out_floor   <= els_pkg::CAR_W'(n_floor);
            r_out_up      <= n_going_up;
            r_out_moving  <= n_has_target;
            r_out_arrived <= n_arrived;
            r_out_status  <= n_dup;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_car_floor  = r_out_floor;
    assign o_heading_up = r_out_up;
    assign o_moving     = r_out_moving;
    assign o_arrived    = r_out_arrived;
    assign o_status     = r_out_status;

endmodule

>>> tb/tb_elevator_look_scheduler.sv
// Testbench for elevator_look_scheduler: directed call/tick cases, random traffic and a
// long output hold-off, each result checked against a cycle-free scheduler predictor.
// Depends on els_pkg and the elevator_look_scheduler RTL.
`timescale 1ns / 1ps

module tb_elevator_look_scheduler;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_LEN       = 250;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int CHUNK_ITEMS    = 140;

    typedef struct packed {
        els_pkg::t_floor car_floor;
        logic            heading_up;
        logic            moving;
        logic            arrived;
        logic            status;
    } t_car_report;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       i_cmd        = els_pkg::CMD_CALL;
    logic [3:0] i_call_floor = '0;
    logic       i_call_down  = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [3:0] o_car_floor;
    logic       o_heading_up;
    logic       o_moving;
    logic       o_arrived;
    logic       o_status;

    elevator_look_scheduler u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_call_floor (i_call_floor),
        .i_call_down  (i_call_down),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_car_floor  (o_car_floor),
        .o_heading_up (o_heading_up),
        .o_moving     (o_moving),
        .o_arrived    (o_arrived),
        .o_status     (o_status)
    );

    // predicted scheduler state
    els_pkg::t_calls up_calls;
    els_pkg::t_calls dn_calls;
    els_pkg::t_floor car_at;
    logic            car_up;
    els_pkg::t_floor tgt_floor;
    logic            tgt_valid;

    t_car_report report_q[$];
    int          bad_count   = 0;
    int          idle_cycles = 0;
    logic        tx_gaps_on  = 1'b0;
    logic        rx_stall_on = 1'b0;
    logic        hold_req    = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic els_pkg::t_floor first_set(input els_pkg::t_calls v);
        for (int i = 0; i < els_pkg::NUM_FLOORS; i++) begin
            if (v[i]) return els_pkg::t_floor'(i);
        end
        return '0;
    endfunction

    function automatic els_pkg::t_floor last_set(input els_pkg::t_calls v);
        for (int i = els_pkg::NUM_FLOORS - 1; i >= 0; i--) begin
            if (v[i]) return els_pkg::t_floor'(i);
        end
        return '0;
    endfunction

    // LOOK target choice; clears the chosen call bit
    function automatic logic pick_target();
        els_pkg::t_calls ahead;
        els_pkg::t_calls same;
        els_pkg::t_calls other;
        els_pkg::t_floor f;
        for (int i = 0; i < els_pkg::NUM_FLOORS; i++) begin
            ahead[i] = car_up ? (i > int'(car_at)) : (i < int'(car_at));
        end
        same  = car_up ? up_calls : dn_calls;
        other = car_up ? dn_calls : up_calls;
        if (same[car_at]) begin
            if (car_up) up_calls[car_at] = 1'b0;
            else dn_calls[car_at] = 1'b0;
            tgt_floor = car_at;
            return 1'b1;
        end
        if ((same & ahead) != '0) begin
            f = car_up ? first_set(same & ahead) : last_set(same & ahead);
            if (car_up) up_calls[f] = 1'b0;
            else dn_calls[f] = 1'b0;
            tgt_floor = f;
            return 1'b1;
        end
        if ((other & ahead) != '0) begin
            f = car_up ? last_set(other & ahead) : first_set(other & ahead);
            if (car_up) dn_calls[f] = 1'b0;
            else up_calls[f] = 1'b0;
            tgt_floor = f;
            return 1'b1;
        end
        if ((up_calls | dn_calls) != '0) car_up = ~car_up;
        return 1'b0;
    endfunction

    function automatic t_car_report advance_car(input els_pkg::t_cmd cmd,
                                                input els_pkg::t_floor fl,
                                                input logic dn);
        t_car_report rep;
        logic        arrived_now;
        logic        dup;
        arrived_now = 1'b0;
        dup         = 1'b0;
        if (cmd == els_pkg::CMD_CALL) begin
            if (dn) begin
                if (dn_calls[fl]) dup = 1'b1;
                else dn_calls[fl] = 1'b1;
            end else begin
                if (up_calls[fl]) dup = 1'b1;
                else up_calls[fl] = 1'b1;
            end
        end else begin
            if (!tgt_valid) tgt_valid = pick_target();
            if (tgt_valid) begin
                if (car_at < tgt_floor) begin
                    car_up = 1'b1;
                    car_at = car_at + els_pkg::t_floor'(1);
                end else if (car_at > tgt_floor) begin
                    car_up = 1'b0;
                    car_at = car_at - els_pkg::t_floor'(1);
                end
                if (car_at == tgt_floor) begin
                    arrived_now = 1'b1;
                    tgt_valid   = 1'b0;
                end
            end
        end
        rep.car_floor  = car_at;
        rep.heading_up = car_up;
        rep.moving     = tgt_valid;
        rep.arrived    = arrived_now;
        rep.status     = dup;
        return rep;
    endfunction

    // input transfers feed the predictor, output transfers are checked
    always @(posedge i_clk) begin
        t_car_report want;
        t_car_report pred;
        logic        xfer;
        xfer = 1'b0;
        if (!i_rst_n) begin
            up_calls  = '0;
            dn_calls  = '0;
            car_at    = '0;
            car_up    = 1'b1;
            tgt_floor = '0;
            tgt_valid = 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                pred = advance_car(els_pkg::t_cmd'(i_cmd), i_call_floor, i_call_down);
                report_q.insert(report_q.size(), pred);
                xfer = 1'b1;
            end
            if (o_valid && !i_stall) begin
                xfer = 1'b1;
                if (report_q.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: unexpected result floor=%0d up=%b mov=%b arr=%b st=%b",
                                 $realtime, o_car_floor, o_heading_up, o_moving, o_arrived,
                                 o_status);
                end else begin
                    want = report_q.pop_front();
                    if (o_car_floor !== want.car_floor || o_heading_up !== want.heading_up ||
                        o_moving !== want.moving || o_arrived !== want.arrived ||
                        o_status !== want.status) begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display("%0t: mismatch exp floor=%0d up=%b mov=%b arr=%b st=%b %s",
                                     $realtime, want.car_floor, want.heading_up, want.moving,
                                     want.arrived, want.status,
                                     $sformatf("got floor=%0d up=%b mov=%b arr=%b st=%b",
                                               o_car_floor, o_heading_up, o_moving,
                                               o_arrived, o_status));
                    end
                end
            end
            idle_cycles = xfer ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // receiver: random stalls, or one long hold-off on request
    initial begin
        int   dur;
        logic s;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                s   = 1'b1;
                dur = HOLD_LEN;
            end else if (rx_stall_on) begin
                s   = 1'($urandom_range(0, 1));
                dur = s ? pick_gap() + 1 : $urandom_range(1, 8);
            end else begin
                s   = 1'b0;
                dur = 1;
            end
            i_stall <= s;
            repeat (dur) @(posedge i_clk);
            if (s && dur == HOLD_LEN && hold_req) hold_req = 1'b0;
        end
    end

    task automatic send_item(input els_pkg::t_cmd cmd, input els_pkg::t_floor fl,
                             input logic dn);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_call_floor <= fl;
        i_call_down  <= dn;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic tick();
        send_item(els_pkg::CMD_TICK,
                  els_pkg::t_floor'($urandom_range(0, els_pkg::NUM_FLOORS - 1)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_random_call();
        send_item(els_pkg::CMD_CALL,
                  els_pkg::t_floor'($urandom_range(0, els_pkg::NUM_FLOORS - 1)),
                  1'($urandom_range(0, 1)));
    endtask

    // idle tick, call at the car's floor, duplicates
    task automatic test_call_handling();
        tick();
        send_item(els_pkg::CMD_CALL, 4'd0, 1'b0);
        send_item(els_pkg::CMD_CALL, 4'd0, 1'b0);
        tick();
    endtask

    // opposite call ahead, call on the pending target, reversal, nearest same-way call
    task automatic test_look_order();
        send_item(els_pkg::CMD_CALL, 4'd2, 1'b1);
        tick();
        send_item(els_pkg::CMD_CALL, 4'd2, 1'b1);
        tick();
        tick();
        tick();
        send_item(els_pkg::CMD_CALL, 4'd15, 1'b0);
        send_item(els_pkg::CMD_CALL, 4'd0, 1'b1);
        send_item(els_pkg::CMD_CALL, 4'd1, 1'b1);
        tick();
        tick();
        tick();
        tick();
        send_item(els_pkg::CMD_CALL, 4'd15, 1'b1);
        send_item(els_pkg::CMD_CALL, 4'd15, 1'b1);
    endtask

    task automatic test_random_traffic();
        int call_pct;
        for (int c = 0; c < RANDOM_ITEMS / CHUNK_ITEMS; c++) begin
            tx_gaps_on  = (c == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            rx_stall_on = (c == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            call_pct    = $urandom_range(20, 60);
            for (int k = 0; k < CHUNK_ITEMS; k++) begin
                if ($urandom_range(0, 99) < call_pct)
                    send_random_call();
                else
                    tick();
            end
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        hold_req    = 1'b1;
        for (int k = 0; k < 40; k++) begin
            if (k % 3 == 0)
                send_random_call();
            else
                tick();
        end
        while (hold_req) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_call_handling();
        test_look_order();
        test_random_traffic();
        test_backpressure();
        i_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
design/els_pkg.sv
design/els_pick.sv
design/elevator_look_scheduler.sv
tb/tb_elevator_look_scheduler.sv
